### design/dasm_pkg.sv
// Shared types, register codes and the CORDIC angle table of the angle sensor mapper.
`default_nettype none
package dasm_pkg;

	localparam int RawW    = 12;
	localparam int FixW    = 18;
	localparam int AngW    = 16;
	localparam int ChW     = 3;
	localparam int MulAW   = 20;
	localparam int MulBW   = 19;
	localparam int MulPW   = MulAW + MulBW;
	localparam int ZW      = 24;
	localparam int TabLen  = 24;

	localparam logic [1:0] CFG_EMA_ALPHA  = 2'd0;
	localparam logic [1:0] CFG_CHANGE_THR = 2'd1;
	localparam logic [1:0] CFG_ANGLE_TOL  = 2'd2;

	localparam logic [8:0]     ALPHA_FULL  = 9'd256;
	localparam logic [ZW-1:0]  HALF_TURN   = 24'h800000;
	// Half a turn of offset plus the rounding half of one output unit.
	localparam logic [ZW-1:0]  ANGLE_BIAS  = 24'h800080;
	localparam logic [AngW-1:0] LEVEL_ONE  = 16'h8000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FX,
		S_FY,
		S_FW,
		S_MINMAX,
		S_PX,
		S_PY,
		S_PW,
		S_CORD,
		S_WB,
		S_DIV,
		S_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		MUL_FILT_X,
		MUL_FILT_Y,
		MUL_PROD_X,
		MUL_PROD_Y
	} mul_sel_t;

	// atan(2^-i) in units of 1/2^24 turn.
	function automatic logic [21:0] turn_step(input logic [4:0] i);
		logic [21:0] v;
		unique case (i)
			5'd0:  v = 22'd2097152;
			5'd1:  v = 22'd1238021;
			5'd2:  v = 22'd654136;
			5'd3:  v = 22'd332050;
			5'd4:  v = 22'd166669;
			5'd5:  v = 22'd83416;
			5'd6:  v = 22'd41718;
			5'd7:  v = 22'd20860;
			5'd8:  v = 22'd10430;
			5'd9:  v = 22'd5215;
			5'd10: v = 22'd2608;
			5'd11: v = 22'd1304;
			5'd12: v = 22'd652;
			5'd13: v = 22'd326;
			5'd14: v = 22'd163;
			5'd15: v = 22'd81;
			5'd16: v = 22'd41;
			5'd17: v = 22'd20;
			5'd18: v = 22'd10;
			5'd19: v = 22'd5;
			5'd20: v = 22'd3;
			5'd21: v = 22'd1;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### design/dasm_if.sv
// Valid/ready channel interfaces for request items and result items.
`default_nettype none
interface dasm_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [2:0]  channel;
	logic [11:0] raw_x;
	logic [11:0] raw_y;
	modport source (output valid, req_type, channel, raw_x, raw_y, input ready);
	modport sink   (input valid, req_type, channel, raw_x, raw_y, output ready);
endinterface

interface dasm_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  out_channel;
	logic [15:0] angle;
	logic [15:0] mapped_level;
	logic        next_capture_is_upper;
	logic        angle_valid;
	modport source (output valid, out_channel, angle, mapped_level,
		next_capture_is_upper, angle_valid, input ready);
	modport sink   (input valid, out_channel, angle, mapped_level,
		next_capture_is_upper, angle_valid, output ready);
endinterface
`default_nettype wire

### design/dasm_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none
module dasm_mul (
	input  wire logic                            clk,
	input  wire logic signed [dasm_pkg::MulAW-1:0] a,
	input  wire logic signed [dasm_pkg::MulBW-1:0] b,
	output logic signed [dasm_pkg::MulPW-1:0]      p
);
	import dasm_pkg::*;

	logic signed [MulPW-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= MulPW'(a) * MulPW'(b);
	end

	assign p = p_q;
endmodule
`default_nettype wire

### design/dasm_cordic.sv
// Iterative vectoring CORDIC that returns atan2 in 1/65536 turn plus half a turn.
`default_nettype none
module dasm_cordic #(
	parameter int STEPS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic signed [dasm_pkg::MulPW-1:0] x_in,
	input  wire logic signed [dasm_pkg::MulPW-1:0] y_in,
	output logic                                 done,
	output logic [dasm_pkg::AngW-1:0]            angle
);
	import dasm_pkg::*;

	localparam int NSteps = (STEPS < TabLen) ? STEPS : TabLen;
	localparam int XW = MulPW + 2;

	logic signed [XW-1:0] x_q, y_q, xs, ys;
	logic [ZW-1:0]        z_q, z_sum, tab;
	logic [4:0]           step_q;
	logic                 busy_q, done_q;

	assign xs  = x_q >>> step_q;
	assign ys  = y_q >>> step_q;
	assign tab = ZW'(turn_step(step_q));
	assign z_sum = z_q + ANGLE_BIAS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				// A centered point has no direction; it reads as angle zero.
				if (x_in == '0 && y_in == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q && step_q == 5'(NSteps - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			step_q <= '0;
			if (x_in < 0) begin
				x_q <= -XW'(x_in);
				y_q <= -XW'(y_in);
				z_q <= HALF_TURN;
			end else begin
				x_q <= XW'(x_in);
				y_q <= XW'(y_in);
				z_q <= '0;
			end
		end else if (busy_q) begin
			step_q <= step_q + 5'd1;
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - tab;
			end
		end
	end

	assign done  = done_q;
	assign angle = z_sum[ZW-1:ZW-AngW];
endmodule
`default_nettype wire

### design/dasm_div.sv
// Restoring divider for the Q1.15 level: floor(num * 32768 / den) with num <= den.
`default_nettype none
module dasm_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [dasm_pkg::AngW-1:0]    num,
	input  wire logic [dasm_pkg::AngW-1:0]    den,
	output logic                              done,
	output logic [dasm_pkg::AngW-1:0]         quo
);
	import dasm_pkg::*;

	logic [AngW:0]   rem_q, rem_sub;
	logic [AngW-1:0] den_q, quo_q;
	logic [4:0]      cnt_q;
	logic            busy_q, done_q, ge;

	assign ge      = rem_q >= {1'b0, den_q};
	assign rem_sub = ge ? rem_q - {1'b0, den_q} : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 5'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
			cnt_q <= 5'(AngW);
		end else if (busy_q) begin
			rem_q <= {rem_sub[AngW-1:0], 1'b0};
			quo_q <= {quo_q[AngW-2:0], ge};
			cnt_q <= cnt_q - 5'd1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

### design/dual_axis_angle_sensor_mapper.sv
// Top level of the dual-axis angle sensor mapper: sequencer, channel state and result register.
//
// Channel   Direction  Payload
// req       in         req_type, channel, raw_x, raw_y
// rsp       out        out_channel, angle, mapped_level, next_capture_is_upper, angle_valid
// cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// A seeded sample item passes through acceptance, filtering and products on the single
// multiplier, the CORDIC loop, write-back, the divider loop and the result load; a capture
// item goes from acceptance straight to write-back, the divider and the result load.
// Reset clears the bounds, last angles, capture phases and seeded flags of all channels.
// One item is in work at a time; a finished result waits in the output register, and the
// next transfer on req is taken while it waits, so only a second finished result stalls.
`default_nettype none
module dual_axis_angle_sensor_mapper #(
	parameter int CHANNELS     = 8,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	dasm_req_if.sink         req,
	dasm_rsp_if.source       rsp,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [17:0] cfg_data
);
	import dasm_pkg::*;

	localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Configuration registers.
	logic [8:0]      alpha_q;
	logic [FixW-1:0] thr_q;
	logic [AngW-1:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 9'd77;
			thr_q   <= 18'd128;
			tol_q   <= 16'd910;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EMA_ALPHA:  alpha_q <= cfg_data[8:0];
				CFG_CHANGE_THR: thr_q   <= cfg_data;
				CFG_ANGLE_TOL:  tol_q   <= cfg_data[AngW-1:0];
				default: ;
			endcase
		end
	end

	// Per-channel state. The filter and extremes are only read once a channel is seeded.
	logic [FixW-1:0] fx_mem [CHANNELS];
	logic [FixW-1:0] fy_mem [CHANNELS];
	logic [FixW-1:0] mnx_mem [CHANNELS];
	logic [FixW-1:0] mxx_mem [CHANNELS];
	logic [FixW-1:0] mny_mem [CHANNELS];
	logic [FixW-1:0] mxy_mem [CHANNELS];
	logic [AngW-1:0] lo_mem [CHANNELS];
	logic [AngW-1:0] up_mem [CHANNELS];
	logic [AngW-1:0] ang_mem [CHANNELS];
	logic            ph_mem [CHANNELS];
	logic            sd_mem [CHANNELS];

	seq_state_t state_q, state_d;

	// Working copy of the addressed channel.
	logic            inr_q;
	logic [ChW-1:0]  ch_q;
	logic [IdxW-1:0] idx_q;
	logic [FixW-1:0] rx_q, ry_q, fx_q, fy_q, mnx_q, mxx_q, mny_q, mxy_q;
	logic [AngW-1:0] lo_q, up_q, ang_q, lvl_q;
	logic            ph_q, sd_q;
	logic signed [MulPW-1:0] px_q;

	logic            accept, in_range;
	logic [IdxW-1:0] idx_in;

	assign accept   = req.valid && req.ready;
	assign idx_in   = IdxW'(req.channel);
	assign in_range = {29'd0, req.channel} < 32'(CHANNELS);

	// Shared multiplier operands.
	mul_sel_t                 mul_sel;
	logic signed [MulAW-1:0]  mul_a, dx, dy;
	logic signed [MulBW-1:0]  mul_b;
	logic signed [MulPW-1:0]  mul_p;
	logic [8:0]               alpha_c;

	assign alpha_c = (alpha_q > ALPHA_FULL) ? ALPHA_FULL : alpha_q;
	assign dx = MulAW'({fx_q, 1'b0}) - MulAW'(mxx_q) - MulAW'(mnx_q);
	assign dy = MulAW'({fy_q, 1'b0}) - MulAW'(mxy_q) - MulAW'(mny_q);

	always_comb begin
		unique case (mul_sel)
			MUL_FILT_X: begin
				mul_a = MulAW'(alpha_c);
				mul_b = MulBW'(rx_q) - MulBW'(fx_q);
			end
			MUL_FILT_Y: begin
				mul_a = MulAW'(alpha_c);
				mul_b = MulBW'(ry_q) - MulBW'(fy_q);
			end
			MUL_PROD_X: begin
				mul_a = dx;
				mul_b = MulBW'(mxy_q - mny_q);
			end
			default: begin
				mul_a = dy;
				mul_b = MulBW'(mxx_q - mnx_q);
			end
		endcase
	end

	dasm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// Filter step: old + round(alpha * (new - old) / 256), kept only past the threshold.
	logic signed [MulPW-1:0] flt_sum;
	logic signed [19:0]      flt_t, flt_abs;
	logic                    flt_take;

	assign flt_sum  = (mul_p + MulPW'(128)) >>> 8;
	assign flt_t    = flt_sum[19:0];
	assign flt_abs  = flt_t[19] ? -flt_t : flt_t;
	assign flt_take = flt_abs > {2'b00, thr_q};

	function automatic logic [FixW-1:0] flt_apply(input logic [FixW-1:0] old,
		input logic signed [19:0] t, input logic take);
		logic [FixW:0] s;
		s = {1'b0, old} + t[FixW:0];
		return take ? s[FixW-1:0] : old;
	endfunction

	logic spans_ok;
	assign spans_ok = (mxx_q != mnx_q) && (mxy_q != mny_q);

	// CORDIC and divider.
	logic            cord_start, cord_done, div_start, div_done;
	logic [AngW-1:0] cord_angle, div_quo, range_w, delta_w;
	logic            map_special;

	assign range_w     = up_q - lo_q;
	assign delta_w     = ang_q - lo_q + tol_q;
	assign map_special = (range_w == '0) || (delta_w > range_w);

	dasm_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.x_in   (px_q),
		.y_in   (mul_p),
		.done   (cord_done),
		.angle  (cord_angle)
	);

	dasm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (delta_w),
		.den    (range_w),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Result register.
	logic            out_valid_q, out_load;
	logic [ChW-1:0]  o_ch_q;
	logic [AngW-1:0] o_ang_q, o_lvl_q;
	logic            o_ph_q, o_vld_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!in_range) begin
						state_d = S_DONE;
					end else if (req.req_type) begin
						state_d = S_WB;
					end else if (!sd_mem[idx_in]) begin
						state_d = S_MINMAX;
					end else begin
						state_d = S_FX;
					end
				end
			end
			S_FX:     state_d = S_FY;
			S_FY:     state_d = S_FW;
			S_FW:     state_d = S_MINMAX;
			S_MINMAX: state_d = S_PX;
			S_PX:     state_d = spans_ok ? S_PY : S_WB;
			S_PY:     state_d = S_PW;
			S_PW:     state_d = S_CORD;
			S_CORD:   state_d = cord_done ? S_WB : S_CORD;
			S_WB:     state_d = map_special ? S_DONE : S_DIV;
			S_DIV:    state_d = div_done ? S_DONE : S_DIV;
			S_DONE:   state_d = out_load ? S_IDLE : S_DONE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		req.ready  = 1'b0;
		mul_sel    = MUL_FILT_X;
		cord_start = 1'b0;
		div_start  = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			S_IDLE: req.ready = 1'b1;
			S_FY:   mul_sel = MUL_FILT_Y;
			S_PX:   mul_sel = MUL_PROD_X;
			S_PY:   mul_sel = MUL_PROD_Y;
			S_PW:   cord_start = 1'b1;
			S_WB:   div_start = !map_special;
			S_DONE: out_load = !out_valid_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					inr_q <= in_range;
					ch_q  <= req.channel;
					idx_q <= idx_in;
					rx_q  <= {req.raw_x, 6'd0};
					ry_q  <= {req.raw_y, 6'd0};
					ang_q <= ang_mem[idx_in];
					lvl_q <= '0;
					if (!req.req_type && !sd_mem[idx_in]) begin
						// The first sample seeds the filter and both extremes.
						fx_q  <= {req.raw_x, 6'd0};
						mnx_q <= {req.raw_x, 6'd0};
						mxx_q <= {req.raw_x, 6'd0};
						fy_q  <= {req.raw_y, 6'd0};
						mny_q <= {req.raw_y, 6'd0};
						mxy_q <= {req.raw_y, 6'd0};
						sd_q  <= 1'b1;
					end else begin
						fx_q  <= fx_mem[idx_in];
						fy_q  <= fy_mem[idx_in];
						mnx_q <= mnx_mem[idx_in];
						mxx_q <= mxx_mem[idx_in];
						mny_q <= mny_mem[idx_in];
						mxy_q <= mxy_mem[idx_in];
						sd_q  <= sd_mem[idx_in];
					end
					// Captures alternate between the lower and the upper bound.
					ph_q <= req.req_type ? !ph_mem[idx_in] : ph_mem[idx_in];
					lo_q <= (req.req_type && !ph_mem[idx_in]) ? ang_mem[idx_in] : lo_mem[idx_in];
					up_q <= (req.req_type && ph_mem[idx_in]) ? ang_mem[idx_in] : up_mem[idx_in];
				end
			end
			S_FY: fx_q <= flt_apply(fx_q, flt_t, flt_take);
			S_FW: fy_q <= flt_apply(fy_q, flt_t, flt_take);
			S_MINMAX: begin
				if (fx_q < mnx_q) mnx_q <= fx_q;
				if (fx_q > mxx_q) mxx_q <= fx_q;
				if (fy_q < mny_q) mny_q <= fy_q;
				if (fy_q > mxy_q) mxy_q <= fy_q;
			end
			S_PY: px_q <= mul_p;
			S_CORD: begin
				if (cord_done) ang_q <= cord_angle;
			end
			S_WB: begin
				if (map_special) lvl_q <= LEVEL_ONE;
			end
			S_DIV: begin
				if (div_done) lvl_q <= div_quo;
			end
			default: ;
		endcase
	end

	// Channel state write-back.
	always_ff @(posedge clk) begin
		if (state_q == S_WB && inr_q) begin
			fx_mem[idx_q]  <= fx_q;
			fy_mem[idx_q]  <= fy_q;
			mnx_mem[idx_q] <= mnx_q;
			mxx_mem[idx_q] <= mxx_q;
			mny_mem[idx_q] <= mny_q;
			mxy_mem[idx_q] <= mxy_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				lo_mem[i]  <= '0;
				up_mem[i]  <= '0;
				ang_mem[i] <= '0;
				ph_mem[i]  <= 1'b0;
				sd_mem[i]  <= 1'b0;
			end
		end else if (state_q == S_WB && inr_q) begin
			lo_mem[idx_q]  <= lo_q;
			up_mem[idx_q]  <= up_q;
			ang_mem[idx_q] <= ang_q;
			ph_mem[idx_q]  <= ph_q;
			sd_mem[idx_q]  <= sd_q;
		end
	end

	// Output register: a channel outside the configured count reports zeros beside its number.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_ch_q  <= ch_q;
			o_ang_q <= inr_q ? ang_q : '0;
			o_lvl_q <= inr_q ? lvl_q : '0;
			o_ph_q  <= inr_q && ph_q;
			o_vld_q <= inr_q && sd_q && spans_ok;
		end
	end

	assign rsp.valid                 = out_valid_q;
	assign rsp.out_channel           = o_ch_q;
	assign rsp.angle                 = o_ang_q;
	assign rsp.mapped_level          = o_lvl_q;
	assign rsp.next_capture_is_upper = o_ph_q;
	assign rsp.angle_valid           = o_vld_q;

	// The sequencer leaves idle after every accepted item.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("sequencer stayed idle after an accepted item");

	// The CORDIC only finishes while the sequencer waits for it.
	a_cordic_done_owner: assert property (@(posedge clk) disable iff (!arst_n)
		cord_done |-> state_q == S_CORD)
		else $error("CORDIC finished outside its wait state");

	// The divider only finishes while the sequencer waits for it.
	a_div_done_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside its wait state");

	// A mapped level never exceeds 1.0.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.mapped_level <= LEVEL_ONE)
		else $error("mapped level above 1.0");

	// A result is never overwritten while it waits.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |=> out_valid_q && $stable(o_lvl_q) && $stable(o_ang_q))
		else $error("waiting result was lost or changed");

endmodule
`default_nettype wire
